@@ hw/rtl/drfe_pkg.sv @@
`default_nettype none
package drfe_pkg;

    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int MaxDrops  = 64;
    localparam int PixAw     = 12;
    localparam int DropAw    = 6;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_EMIT    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_DROPS  = 3'd2,
        REG_SPEED  = 3'd3,
        REG_FADE   = 3'd4,
        REG_RED    = 3'd5,
        REG_GREEN  = 3'd6,
        REG_BLUE   = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EMIT,
        ST_ADV,
        ST_FILL,
        ST_DONE
    } t_state;

    // Drop entry: column, signed Q8.8 position, length, Q5.8 speed.
    typedef struct packed {
        logic [5:0]         column;
        logic signed [15:0] pos;
        logic [5:0]         len;
        logic [12:0]        speed;
    } t_drop;

    // Pixel store write request. The head bit is only written when head_we is
    // set, so that trail rows keep any head mark already stored there.
    typedef struct packed {
        logic             we;
        logic             head_we;
        logic [PixAw-1:0] addr;
        logic [15:0]      bright;
        logic             head;
    } t_pix_wr;

    function automatic logic [12:0] make_speed(input logic [11:0] base,
                                               input logic [7:0] frac);
        logic [20:0] prod;
        logic [12:0] s;
        prod = base * ({1'b0, frac} + 9'd128);
        s = (prod[20:8] > 13'd8191) ? 13'd8191 : prod[20:8];
        return s;
    endfunction

    function automatic logic signed [8:0] row_of(input logic signed [15:0] pos);
        logic [15:0] mag;
        logic [7:0]  r;
        mag = pos[15] ? 16'(-pos) : pos;
        r = mag[15:8];
        return pos[15] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/drfe_pixel_mem.sv @@
`default_nettype none
module drfe_pixel_mem (
    input  wire logic                      i_clk,
    input  wire logic [drfe_pkg::PixAw-1:0] i_rd_addr,
    input  wire drfe_pkg::t_pix_wr          i_wr,
    output logic [15:0]                     o_bright,
    output logic                            o_head
);
    import drfe_pkg::*;

    logic [16:0] r_mem [0:(1 << PixAw) - 1];
    logic [16:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr][15:0] <= i_wr.bright;
            if (i_wr.head_we) begin
                r_mem[i_wr.addr][16] <= i_wr.head;
            end
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_bright = r_q[15:0];
    assign o_head   = r_q[16];
endmodule
`default_nettype wire

@@ hw/rtl/drfe_drop_mem.sv @@
`default_nettype none
module drfe_drop_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [drfe_pkg::DropAw-1:0] i_wr_addr,
    input  wire drfe_pkg::t_drop             i_wr_data,
    input  wire logic [drfe_pkg::DropAw-1:0] i_rd_addr,
    output drfe_pkg::t_drop                  o_rd_data
);
    import drfe_pkg::*;

    t_drop r_mem [0:MaxDrops-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/digital_rain_frame_engine.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         i_start high, o_busy low   i_command .. i_pixel_row
// result    out        o_done strobe, one cycle   o_out_red .. o_drop_restarted
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// Load writes the drop entry from its read state; emit is
// a read-modify-write of the pixel memory through its registered read port.
// Advance reads the drop entry, then writes its lit trail rows in turn to the pixel memory.
// After reset a clearing pass sweeps all 4096 pixel entries,
// with busy high; configuration writes are taken throughout.
// The receiver cannot stall: each result is flagged by o_done for exactly one cycle.
`default_nettype none
module digital_rain_frame_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [5:0]  i_drop_index,
    input  wire logic [5:0]  i_drop_column,
    input  wire logic signed [14:0] i_drop_row_pos,
    input  wire logic [5:0]  i_drop_len,
    input  wire logic [5:0]  i_start_len,
    input  wire logic [7:0]  i_speed_fraction,
    input  wire logic [5:0]  i_pixel_col,
    input  wire logic [5:0]  i_pixel_row,
    output logic             o_done,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_is_head,
    output logic             o_drop_restarted,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import drfe_pkg::*;

    t_state r_state, n_state;
    logic [PixAw:0] r_clr, n_clr;

    logic [6:0]  r_width, r_height, r_drops;
    logic [11:0] r_base;
    logic [15:0] r_fade;
    logic [7:0]  r_red, r_green, r_blue;

    t_cmd        r_cmd;
    logic [5:0]  r_idx, r_col_in, r_len_in, r_slen, r_pcol, r_prow;
    logic signed [14:0] r_pos_in;
    logic [7:0]  r_frac;

    t_drop       r_drop, n_drop;
    logic [6:0]  r_y, n_y;
    logic [6:0]  r_yend, n_yend;
    logic        r_mark, n_mark;

    logic [7:0]  r_ored, r_ogreen, r_oblue;
    logic        r_ohead, r_orst, r_done;
    logic [7:0]  n_ored, n_ogreen, n_oblue;
    logic        n_ohead, n_orst;

    logic [6:0] w_eff, h_eff;
    assign w_eff = (r_width  > 7'(MaxWidth))  ? 7'(MaxWidth)  : r_width;
    assign h_eff = (r_height > 7'(MaxHeight)) ? 7'(MaxHeight) : r_height;

    t_pix_wr     pix_wr;
    logic [PixAw-1:0] pix_rd_addr;
    logic [15:0] pix_bright;
    logic        pix_head;

    logic        drop_we;
    t_drop       drop_wdata, drop_q;

    drfe_pixel_mem u_pix (
        .i_clk     (i_clk),
        .i_rd_addr (pix_rd_addr),
        .i_wr      (pix_wr),
        .o_bright  (pix_bright),
        .o_head    (pix_head)
    );

    drfe_drop_mem u_drop (
        .i_clk     (i_clk),
        .i_we      (drop_we),
        .i_wr_addr (r_idx),
        .i_wr_data (drop_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (drop_q)
    );

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd32;
            r_drops  <= 7'd32;
            r_base   <= 12'd128;
            r_fade   <= 16'd58982;
            r_red    <= 8'd0;
            r_green  <= 8'd255;
            r_blue   <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_WIDTH:  r_width  <= i_cfg_data[6:0];
                REG_HEIGHT: r_height <= i_cfg_data[6:0];
                REG_DROPS:  r_drops  <= i_cfg_data[6:0];
                REG_SPEED:  r_base   <= i_cfg_data[11:0];
                REG_FADE:   r_fade   <= i_cfg_data;
                REG_RED:    r_red    <= i_cfg_data[7:0];
                REG_GREEN:  r_green  <= i_cfg_data[7:0];
                REG_BLUE:   r_blue   <= i_cfg_data[7:0];
            endcase
        end
    end

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(i_command);
            r_idx    <= i_drop_index;
            r_col_in <= i_drop_column;
            r_pos_in <= i_drop_row_pos;
            r_len_in <= i_drop_len;
            r_slen   <= i_start_len;
            r_frac   <= i_speed_fraction;
            r_pcol   <= i_pixel_col;
            r_prow   <= i_pixel_row;
        end
    end

    // Advance arithmetic on the entry just read.
    logic signed [8:0]  old_row, new_row;
    logic signed [17:0] np_wide;
    logic signed [15:0] np;
    logic               in_area, restart;
    logic [6:0]         y_start;
    always_comb begin
        old_row = row_of(drop_q.pos);
        np_wide = 18'(drop_q.pos) + 18'($signed({1'b0, drop_q.speed}));
        np      = (np_wide > 18'sd32767) ? 16'sd32767 : np_wide[15:0];
        new_row = row_of(np);
        in_area = !new_row[8] && (7'(new_row) < h_eff) && ({1'b0, drop_q.column} < w_eff);
        restart = 18'(np) > $signed({3'd0, 15'(({8'd0, h_eff} + {9'd0, drop_q.len}) << 8)});
        y_start = old_row[8] ? 7'd0 : 7'(old_row);
    end

    // Emit datapath.
    logic [23:0] cr, cg, cb;
    logic [31:0] faded;
    logic        emit_ok;
    always_comb begin
        cr = r_red   * pix_bright;
        cg = r_green * pix_bright;
        cb = r_blue  * pix_bright;
        faded = pix_bright * r_fade;
        emit_ok = ({1'b0, r_pcol} < w_eff) && ({1'b0, r_prow} < h_eff);
    end

    function automatic logic [7:0] div65535(input logic [23:0] p);
        logic [24:0] q;
        q = (25'(p) + 25'(p >> 16) + 25'd1) >> 16;
        return q[7:0];
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_CLEAR: begin
                if (r_clr == {1'b0, {PixAw{1'b1}}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                unique case (r_cmd)
                    CMD_EMIT:    n_state = ST_EMIT;
                    CMD_ADVANCE: n_state = ({1'b0, r_idx} < r_drops) ? ST_ADV : ST_DONE;
                    CMD_LOAD,
                    CMD_NONE:    n_state = ST_DONE;
                endcase
            end
            ST_EMIT: n_state = ST_DONE;
            ST_ADV:  n_state = (in_area && y_start <= 7'(new_row)) ? ST_FILL : ST_DONE;
            ST_FILL: n_state = (r_y >= r_yend) ? ST_DONE : ST_FILL;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;
        n_drop = r_drop;
        n_y = r_y;
        n_yend = r_yend;
        n_mark = r_mark;
        n_ored = r_ored;
        n_ogreen = r_ogreen;
        n_oblue = r_oblue;
        n_ohead = r_ohead;
        n_orst = r_orst;
        pix_wr = '0;
        pix_rd_addr = {r_pcol, r_prow};
        drop_we = 1'b0;
        drop_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                pix_wr.we = 1'b1;
                pix_wr.head_we = 1'b1;
                pix_wr.addr = r_clr[PixAw-1:0];
                n_clr = r_clr + 1'b1;
            end
            ST_IDLE: begin
                pix_rd_addr = {i_pixel_col, i_pixel_row};
                if (accept) begin
                    {n_ored, n_ogreen, n_oblue, n_ohead, n_orst} = '0;
                end
            end
            ST_READ: begin
                if (r_cmd == CMD_LOAD) begin
                    drop_we = 1'b1;
                    drop_wdata.column = r_col_in;
                    drop_wdata.pos = 16'(r_pos_in);
                    drop_wdata.len = r_len_in;
                    drop_wdata.speed = make_speed(r_base, r_frac);
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    if (pix_head) begin
                        n_ored = 8'd255;
                        n_ogreen = 8'd255;
                        n_oblue = 8'd255;
                        n_ohead = 1'b1;
                    end else if (pix_bright > 16'd655) begin
                        n_ored = div65535(cr);
                        n_ogreen = div65535(cg);
                        n_oblue = div65535(cb);
                    end
                    pix_wr.we = 1'b1;
                    pix_wr.head_we = 1'b1;
                    pix_wr.addr = {r_pcol, r_prow};
                    pix_wr.bright = faded[31:16];
                    pix_wr.head = 1'b0;
                end
            end
            ST_ADV: begin
                drop_we = 1'b1;
                n_drop = drop_q;
                n_y = y_start;
                n_yend = 7'(new_row);
                n_mark = in_area && !restart;
                if (restart) begin
                    drop_wdata.column = r_col_in;
                    drop_wdata.pos = -$signed({2'b0, r_slen, 8'd0});
                    drop_wdata.len = r_len_in;
                    drop_wdata.speed = make_speed(r_base, r_frac);
                    n_orst = 1'b1;
                end else begin
                    drop_wdata = drop_q;
                    drop_wdata.pos = np;
                end
                // The head mark sits on the last filled row, so no fill means
                // the head is written here on its own.
                if (!(in_area && y_start <= 7'(new_row)) && n_mark) begin
                    pix_wr.we = 1'b1;
                    pix_wr.head_we = 1'b1;
                    pix_wr.addr = {drop_q.column, 6'(new_row)};
                    pix_wr.bright = 16'hFFFF;
                    pix_wr.head = 1'b1;
                end
            end
            ST_FILL: begin
                pix_wr.we = 1'b1;
                pix_wr.head_we = r_mark && (r_y == r_yend);
                pix_wr.addr = {r_drop.column, r_y[5:0]};
                pix_wr.bright = 16'hFFFF;
                pix_wr.head = 1'b1;
                n_y = r_y + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop   <= n_drop;
        r_y      <= n_y;
        r_yend   <= n_yend;
        r_mark   <= n_mark;
        r_ored   <= n_ored;
        r_ogreen <= n_ogreen;
        r_oblue  <= n_oblue;
        r_ohead  <= n_ohead;
        r_orst   <= n_orst;
    end

    assign o_done = r_done;
    assign o_out_red = r_ored;
    assign o_out_green = r_ogreen;
    assign o_out_blue = r_oblue;
    assign o_is_head = r_ohead;
    assign o_drop_restarted = r_orst;

    a_done_after_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_done) else $error("result strobe missing");
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_busy) else $error("idle during clearing pass");
    a_head_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_head) |-> (o_out_red == 8'd255 && o_out_blue == 8'd255))
        else $error("head pixel not white");
    a_restart_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_head && o_drop_restarted)) else $error("mixed result");
endmodule
`default_nettype wire
